// File: design/xks_pkg.sv
// Shared types, codes and constants of the XMODEM-1K CRC sender.
package xks_pkg;

  // Input item kinds (carried on tuser)
  localparam logic [1:0] FUNC_REPLY = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_PACKET   = 3'd1;
  localparam logic [2:0] ACT_EOT      = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_ABORT    = 3'd4;
  localparam logic [2:0] ACT_RETRY    = 3'd5;
  localparam logic [2:0] ACT_READ_ERR = 3'd6;

  // Protocol characters
  localparam logic [7:0] CH_START = 8'h43;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_PAD   = 8'h1A;
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CODE_NONE = 8'hFF;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Progress scaling
  localparam logic [6:0] PROGRESS_FULL = 7'd98;
  localparam logic [6:0] PROGRESS_DONE = 7'd99;

  // Register indexes
  localparam logic REG_FILE_BYTES = 1'b0;
  localparam logic REG_NAK_LIMIT  = 1'b1;

  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [4:0] NAK_MAX = '1;

  // One result item
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  header;
    logic [7:0]  number;
    logic [7:0]  number_inv;
    logic [15:0] crc;
    logic [6:0]  progress;
  } result_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic       done;
    logic [6:0] quotient;
  } div_result_t;

endpackage

// File: design/xks_crc.sv
// CRC-16 (poly 0x1021) byte step, shared by data bytes and pad bytes.
module xks_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import xks_pkg::*;

  // Eight bit steps, MSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: design/xks_div.sv
// Progress divider: position*98/size, one quotient bit per cycle.
module xks_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              position,
  input  logic [31:0]              total,
  output xks_pkg::div_result_t     result
);
  import xks_pkg::*;

  logic [31:0] rem;
  logic [31:0] divisor;
  logic [6:0]  low;
  logic [6:0]  quo;
  logic [2:0]  cnt;
  logic        running;
  logic        done;
  logic [38:0] prod;
  logic        sat;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // Scaled dividend; a quotient of 98 or more, or a zero size, saturates right away
  assign prod  = 39'(position) * 39'(PROGRESS_FULL);
  assign sat   = (total == 32'd0) || (position >= total);
  assign trial = {rem, low[6]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Control: seven steps, done pulses once the last quotient bit is in
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (start) begin
        running <= !sat;
        done    <= sat;
        cnt     <= 3'd7;
      end else if (running) begin
        cnt     <= cnt - 3'd1;
        running <= (cnt != 3'd1);
        done    <= (cnt == 3'd1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath: restoring division, dividend high part below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= prod[38:7];
      low     <= prod[6:0];
      divisor <= total;
      quo     <= PROGRESS_FULL;
    end else if (running) begin
      rem <= fits ? diff[31:0] : trial[31:0];
      low <= {low[5:0], 1'b0};
      quo <= {quo[5:0], fits};
    end
  end

  assign result.done     = done;
  assign result.quotient = quo;

endmodule

// File: design/xmodem_1k_crc_sender_core.sv
// XMODEM-1K CRC sender: packet field generator and reply sequencer.
//
// Channel | Dir | Handshake          | Content
// s_*     | in  | s_tvalid/s_tready  | reply byte, data byte or chunk end
// m_*     | out | m_tvalid/m_tready  | action and packet header fields
// cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// Data bytes and reply bytes not marked last leave the sequencer idle.
// A reply marked last is decided and stored in res, then loaded into the
// output register from the emit state. Chunk end waits in the divide state
// for the bit-serial progress divider, which skips its division steps when
// the position reaches the file size or the size is zero. A data packet that
// needs padding runs the shared CRC unit over the pad bytes up to the block end.
// Reset is synchronous; the output register frees the input side, so only
// a second reply waits on a stalled result.
module xmodem_1k_crc_sender_core #(
  parameter int BLOCK_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // byte_value[7:0], read_error[8], file_position[40:9]
  input  logic [1:0]  s_tuser,   // func[1:0]
  input  logic        s_tlast,   // reply_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // action[2:0], header_byte[10:3], packet_number[18:11],
                                 // packet_number_inverse[26:19], block_crc[42:27],
                                 // progress_percent[49:43]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import xks_pkg::*;

  localparam logic [COUNT_W-1:0] BLOCK_LEN  = COUNT_W'(BLOCK_BYTES);
  localparam logic [COUNT_W-1:0] BLOCK_LAST = COUNT_W'(BLOCK_BYTES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PAD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [31:0]        total_file_bytes;
  logic [3:0]         nak_retry_limit;
  logic               session_open;
  logic [7:0]         sequence_count;
  logic [4:0]         nak_count;
  logic [7:0]         reply_code;
  logic [15:0]        crc_accumulator;
  logic [COUNT_W-1:0] chunk_byte_count;
  logic               chunk_error;
  logic [6:0]         progress_value;
  logic [6:0]         staged_progress;
  result_t            res;
  result_t            res_dec;

  logic [1:0]  func;
  logic [7:0]  byte_value;
  logic        accept;
  logic [7:0]  code;
  logic        issue;
  logic [7:0]  seq_new;
  logic [6:0]  prog_base;
  logic        chunk_bad;
  logic        pad_needed;
  logic        out_load;
  logic        div_start;
  logic [15:0] crc_out;
  logic [7:0]  crc_byte;
  div_result_t div_res;

  assign func       = s_tuser;
  assign byte_value = s_tdata[7:0];
  assign s_tready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = s_tvalid && s_tready;
  assign div_start  = accept && (func == FUNC_END);
  assign out_load   = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Reply decision terms
  assign code       = (byte_value != 8'd0) ? byte_value : reply_code;
  assign issue      = session_open ? (code == CH_ACK && progress_value != PROGRESS_DONE)
                                   : (code == CH_START);
  assign seq_new    = (session_open ? sequence_count : 8'd0) + 8'd1;
  assign prog_base  = session_open ? progress_value : 7'd0;
  assign chunk_bad  = chunk_error || (chunk_byte_count > BLOCK_LEN);
  assign pad_needed = issue && !chunk_bad && (chunk_byte_count != '0) &&
                      (chunk_byte_count != BLOCK_LEN);

  // Result fields of a decided reply
  always_comb begin
    res_dec          = '0;
    res_dec.progress = progress_value;
    if (issue) begin
      if (chunk_bad) begin
        res_dec.action   = ACT_READ_ERR;
        res_dec.progress = prog_base;
      end else if (chunk_byte_count == '0) begin
        res_dec.action     = ACT_EOT;
        res_dec.header     = CH_EOT;
        res_dec.number     = seq_new;
        res_dec.number_inv = ~seq_new;
        res_dec.progress   = PROGRESS_DONE;
      end else begin
        res_dec.action     = ACT_PACKET;
        res_dec.header     = CH_STX;
        res_dec.number     = seq_new;
        res_dec.number_inv = ~seq_new;
        res_dec.crc        = crc_accumulator;  // final only for a full block
        res_dec.progress   = staged_progress;
      end
    end else if (session_open) begin
      case (code)
        CH_ETX, CH_CAN: res_dec.action = ACT_ABORT;
        CH_ACK:         res_dec.action = ACT_COMPLETE;  // only after EOT
        CH_NAK: begin
          if (nak_count > {1'b0, nak_retry_limit}) res_dec.action = ACT_RETRY;
        end
        default: ;
      endcase
    end
  end

  // Shared CRC byte unit
  assign crc_byte = (state == ST_PAD) ? CH_PAD : byte_value;

  xks_crc u_crc (
    .crc_in  (crc_accumulator),
    .data_in (crc_byte),
    .crc_out (crc_out)
  );

  xks_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .position (s_tdata[40:9]),
    .total    (total_file_bytes),
    .result   (div_res)
  );

  // Sequencer and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      total_file_bytes <= 32'd1;
      nak_retry_limit  <= 4'd10;
      session_open     <= 1'b0;
      sequence_count   <= '0;
      nak_count        <= '0;
      reply_code       <= CODE_NONE;
      crc_accumulator  <= '0;
      chunk_byte_count <= '0;
      chunk_error      <= 1'b0;
      progress_value   <= '0;
      staged_progress  <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FILE_BYTES: total_file_bytes <= cfg_data;
          REG_NAK_LIMIT:  nak_retry_limit  <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (func)
              FUNC_DATA: begin
                if (chunk_byte_count < BLOCK_LEN) crc_accumulator <= crc_out;
                if (chunk_byte_count != COUNT_MAX)
                  chunk_byte_count <= chunk_byte_count + COUNT_W'(1);
              end
              FUNC_END: begin
                if (s_tdata[8]) chunk_error <= 1'b1;
                state <= ST_DIV;
              end
              FUNC_REPLY: begin
                if (!s_tlast) begin
                  if (byte_value != 8'd0) reply_code <= byte_value;
                end else begin
                  reply_code <= CODE_NONE;
                  res        <= res_dec;
                  state      <= pad_needed ? ST_PAD : ST_EMIT;
                  if (issue) begin
                    // Next packet, EOT or read error
                    nak_count      <= '0;
                    sequence_count <= seq_new;
                    session_open   <= !chunk_bad;
                    if (chunk_bad) begin
                      crc_accumulator  <= '0;
                      chunk_byte_count <= '0;
                      chunk_error      <= 1'b0;
                      progress_value   <= prog_base;
                    end else if (chunk_byte_count == '0) begin
                      crc_accumulator  <= '0;
                      chunk_error      <= 1'b0;
                      progress_value   <= PROGRESS_DONE;
                    end else begin
                      progress_value   <= staged_progress;
                      if (chunk_byte_count == BLOCK_LEN) begin
                        crc_accumulator  <= '0;
                        chunk_byte_count <= '0;
                        chunk_error      <= 1'b0;
                      end
                    end
                  end else if (session_open) begin
                    case (code)
                      CH_ETX, CH_CAN: begin
                        session_open <= 1'b0;
                      end
                      CH_ACK: begin
                        // Only reached after EOT was sent
                        nak_count    <= '0;
                        session_open <= 1'b0;
                      end
                      CH_NAK: begin
                        if (nak_count != NAK_MAX) nak_count <= nak_count + 5'd1;
                        if (nak_count > {1'b0, nak_retry_limit}) session_open <= 1'b0;
                      end
                      default: ;
                    endcase
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            staged_progress <= div_res.quotient;
            state           <= ST_IDLE;
          end
        end
        ST_PAD: begin
          if (chunk_byte_count == BLOCK_LAST) begin
            res.crc          <= crc_out;
            crc_accumulator  <= '0;
            chunk_byte_count <= '0;
            chunk_error      <= 1'b0;
            state            <= ST_EMIT;
          end else begin
            crc_accumulator  <= crc_out;
            chunk_byte_count <= chunk_byte_count + COUNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, res.progress, res.crc, res.number_inv, res.number,
                  res.header, res.action};
    end
  end

  // Padding never starts at or past the block end
  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD |-> chunk_byte_count < BLOCK_LEN)
    else $error("pad count out of range");

  // Divider completion returns the sequencer to idle with a bounded quotient
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_res.done |=> state == ST_IDLE && staged_progress <= PROGRESS_FULL)
    else $error("divider completion mishandled");

  // Packet and EOT results carry a complemented number
  a_num_inv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ACT_PACKET || m_tdata[2:0] == ACT_EOT)
      |-> m_tdata[26:19] == ~m_tdata[18:11])
    else $error("packet number complement mismatch");

  // Reported progress never exceeds the done mark
  a_progress: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[49:43] <= PROGRESS_DONE)
    else $error("progress out of range");

endmodule
